// File: rtl/core/mslpd_pkg.sv
// Shared types and codes for the multi-stream length-prefix deframer.
// Holds the per-stream state entry, framing phases, result status codes and register indices.
// No dependencies.
`default_nettype none

package mslpd_pkg;

  localparam int unsigned HDR_BYTES = 2;

  typedef enum logic [1:0] {
    PH_HDR1 = 2'd0,
    PH_HDR2 = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_HDR   = 3'd0,
    ST_BODY  = 3'd1,
    ST_DONE  = 3'd2,
    ST_SHORT = 3'd3,
    ST_LONG  = 3'd4,
    ST_RANGE = 3'd5
  } status_t;

  typedef enum logic {
    REG_ACTIVE_STREAMS   = 1'b0,
    REG_MAX_FRAME_LENGTH = 1'b1
  } reg_index_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  header_low_byte;
    logic [15:0] bytes_remaining;
    logic [15:0] bytes_received;
  } entry_t;

endpackage

`default_nettype wire

// File: rtl/core/multi_stream_length_prefix_deframer.sv
// Top level of the multi-stream length-prefix deframer.
// Per-stream framing state sits in one synchronous memory; depends on mslpd_pkg.
//
//   Channel  Direction  Beat contents
//   s_*      in         stream_id, data_byte
//   m_*      out        stream_echo, status, byte_out, frame_offset; tlast = last_of_frame
//   cfg_*    in         register writes: active_streams, max_frame_length
//
// One beat per cycle sustained while the output is not stalled; each beat passes
// the memory-stage and output registers. The rate is set by the state memory: one
// read and one write per cycle, with the write of a beat forwarded to a read of
// the same stream in the same cycle. Reset clears all stream state at once through
// per-entry valid bits. A stall on the output holds the pipeline; the input still
// takes a beat while the output register is full and the stage ahead of it is empty.
`default_nettype none

module multi_stream_length_prefix_deframer #(
  parameter int unsigned NUM_STREAMS      = 16,
  parameter int unsigned MIN_FRAME_LENGTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [3:0] stream_id, [11:4] data_byte, [15:12] zero
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [3:0] stream_echo, [6:4] status, [14:7] byte_out,
                                      // [30:15] frame_offset, [31] zero
  output logic             m_tlast,
  input  wire logic        cfg_we,
  input  wire mslpd_pkg::reg_index_t cfg_index,
  input  wire logic [15:0] cfg_data
);
  import mslpd_pkg::*;

  localparam int unsigned ADDR_W = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
  localparam logic [15:0] MIN_LEN = 16'(MIN_FRAME_LENGTH);
  localparam logic [15:0] NUM_S   = 16'(NUM_STREAMS);

  logic [4:0]  active_streams;
  logic [15:0] max_frame_length;

  entry_t                 mem [NUM_STREAMS];
  logic [NUM_STREAMS-1:0] valid;

  logic              s1_v;
  logic [3:0]        s1_sid;
  logic [7:0]        s1_byte;
  entry_t            mem_q;
  logic              hit_q;
  logic              fwd_q;
  entry_t            fwd_data;

  logic              o_v;
  logic [3:0]        o_sid;
  status_t           o_status;
  logic [7:0]        o_byte;
  logic [15:0]       o_offset;
  logic              o_last;

  logic              adv;
  logic              s_acc;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] waddr;
  logic              we;
  logic              in_range;
  entry_t            cur;
  entry_t            entry_next;
  status_t           status_next;
  logic [15:0]       offset_next;
  logic              last_next;
  logic [15:0]       len;
  logic [15:0]       maxlen;

  assign adv      = !o_v || m_tready;
  assign s_tready = !s1_v || adv;
  assign s_acc    = s_tvalid && s_tready;
  assign raddr    = ADDR_W'(s_tdata[3:0]);
  assign waddr    = ADDR_W'(s1_sid);

  assign in_range = ({12'b0, s1_sid} < {11'b0, active_streams}) &&
                    ({12'b0, s1_sid} < NUM_S);
  assign maxlen   = (max_frame_length < MIN_LEN) ? MIN_LEN : max_frame_length;
  assign cur      = fwd_q ? fwd_data : (hit_q ? mem_q : '0);
  assign len      = {s1_byte, cur.header_low_byte};
  assign we       = s1_v && adv && in_range;

  always_comb begin
    entry_next  = cur;
    status_next = ST_RANGE;
    offset_next = '0;
    last_next   = 1'b0;
    if (in_range) begin
      case (cur.phase)
        PH_HDR2: begin
          offset_next = 16'd1;
          if (len < MIN_LEN) begin
            status_next = ST_SHORT;
            entry_next  = '0;
          end else if (len == 16'(HDR_BYTES)) begin
            status_next = ST_DONE;
            last_next   = 1'b1;
            entry_next  = '0;
          end else begin
            status_next                = ST_HDR;
            entry_next.bytes_received  = 16'(HDR_BYTES);
            entry_next.bytes_remaining = len - 16'(HDR_BYTES);
            entry_next.phase           = PH_BODY;
          end
        end
        PH_BODY: begin
          offset_next = cur.bytes_received;
          if (({1'b0, cur.bytes_received} + 17'd1) > {1'b0, maxlen}) begin
            status_next = ST_LONG;
            entry_next  = '0;
          end else if (cur.bytes_remaining <= 16'd1) begin
            status_next = ST_DONE;
            last_next   = 1'b1;
            entry_next  = '0;
          end else begin
            status_next                = ST_BODY;
            entry_next.bytes_received  = cur.bytes_received + 16'd1;
            entry_next.bytes_remaining = cur.bytes_remaining - 16'd1;
          end
        end
        default: begin
          status_next                = ST_HDR;
          entry_next.header_low_byte = s1_byte;
          entry_next.bytes_received  = 16'd1;
          entry_next.bytes_remaining = '0;
          entry_next.phase           = PH_HDR2;
        end
      endcase
    end
  end

  // State memory with registered read and write forwarding.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= entry_next;
    end
    if (s_acc) begin
      mem_q    <= mem[raddr];
      fwd_data <= entry_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid            <= '0;
      s1_v             <= 1'b0;
      o_v              <= 1'b0;
      hit_q            <= 1'b0;
      fwd_q            <= 1'b0;
      active_streams   <= 5'd16;
      max_frame_length <= 16'd1024;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ACTIVE_STREAMS:   active_streams   <= cfg_data[4:0];
          REG_MAX_FRAME_LENGTH: max_frame_length <= cfg_data;
          default: ;
        endcase
      end
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      if (s_acc) begin
        hit_q <= valid[raddr];
        fwd_q <= we && (waddr == raddr);
        s1_v  <= 1'b1;
      end else if (adv) begin
        s1_v  <= 1'b0;
      end
      if (adv) begin
        o_v <= s1_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      s1_sid  <= s_tdata[3:0];
      s1_byte <= s_tdata[11:4];
    end
    if (adv && s1_v) begin
      o_sid    <= s1_sid;
      o_status <= status_next;
      o_byte   <= s1_byte;
      o_offset <= offset_next;
      o_last   <= last_next;
    end
  end

  assign m_tvalid = o_v;
  assign m_tdata  = {1'b0, o_offset, o_byte, o_status, o_sid};
  assign m_tlast  = o_last;

  a_last_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> o_status == ST_DONE)
    else $error("last_of_frame without frame complete status");

  a_range_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && o_status == ST_RANGE |-> o_offset == 16'd0 && !o_last)
    else $error("out-of-range beat carries offset or last flag");

  a_write_advance: assert property (@(posedge clk) disable iff (rst)
    we |-> s1_v && adv)
    else $error("state write without a beat moving to the output");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    s1_v && !adv |=> s1_v && $stable(s1_sid) && $stable(s1_byte))
    else $error("stalled beat lost in the memory stage");

endmodule

`default_nettype wire

// File: bench/mslpd_checker.sv
`timescale 1ns / 100ps
// Checker for the multi-stream length-prefix deframer: it predicts each output beat
// from the accepted input beats and register writes, then compares in order.
// Depends on mslpd_pkg for the phase, status and register index codes.
module mslpd_checker (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  input  wire logic                  s_tready,
  input  wire logic [15:0]           s_tdata,
  input  wire logic                  m_tvalid,
  input  wire logic                  m_tready,
  input  wire logic [31:0]           m_tdata,
  input  wire logic                  m_tlast,
  input  wire logic                  cfg_we,
  input  wire mslpd_pkg::reg_index_t cfg_index,
  input  wire logic [15:0]           cfg_data,
  output int                         fail_count,
  output int                         pending_beats,
  output int                         checked_beats
);
  import mslpd_pkg::*;

  localparam int unsigned STREAMS = 16;
  localparam int unsigned MIN_LEN = 2;

  typedef struct packed {
    logic [3:0]  sid;
    status_t     status;
    logic [7:0]  data;
    logic [15:0] offset;
    logic        last;
  } beat_result_t;

  phase_t      fr_phase [STREAMS];
  logic [7:0]  fr_low   [STREAMS];
  logic [15:0] fr_left  [STREAMS];
  logic [15:0] fr_count [STREAMS];
  logic [4:0]  act_reg;
  logic [15:0] max_reg;

  beat_result_t expected_q[$];
  int fails = 0;
  int checked = 0;

  task automatic flush_stream(input int unsigned s);
    fr_phase[s] = PH_HDR1;
    fr_low[s]   = 8'h00;
    fr_left[s]  = 16'h0000;
    fr_count[s] = 16'h0000;
  endtask

  task automatic deframe(input logic [3:0] sid, input logic [7:0] b,
                         output beat_result_t r);
    int unsigned act_eff;
    int unsigned max_eff;
    int unsigned len;
    int unsigned got;
    act_eff = act_reg;
    max_eff = max_reg;
    if (act_eff > STREAMS) act_eff = STREAMS;
    if (max_eff < MIN_LEN) max_eff = MIN_LEN;
    r.sid    = sid;
    r.data   = b;
    r.status = ST_RANGE;
    r.offset = 16'd0;
    r.last   = 1'b0;
    if (sid < act_eff) begin
      case (fr_phase[sid])
        PH_HDR2: begin
          len = {16'h0000, b, fr_low[sid]};
          r.offset = 16'd1;
          if (len < MIN_LEN) begin
            r.status = ST_SHORT;
            flush_stream(sid);
          end else if (len == HDR_BYTES) begin
            r.status = ST_DONE;
            r.last   = 1'b1;
            flush_stream(sid);
          end else begin
            r.status      = ST_HDR;
            fr_count[sid] = 16'(HDR_BYTES);
            fr_left[sid]  = 16'(len - HDR_BYTES);
            fr_phase[sid] = PH_BODY;
          end
        end
        PH_BODY: begin
          got = fr_count[sid];
          r.offset = fr_count[sid];
          if (got + 1 > max_eff) begin
            r.status = ST_LONG;
            flush_stream(sid);
          end else if (fr_left[sid] <= 16'd1) begin
            r.status = ST_DONE;
            r.last   = 1'b1;
            flush_stream(sid);
          end else begin
            r.status      = ST_BODY;
            fr_count[sid] = fr_count[sid] + 16'd1;
            fr_left[sid]  = fr_left[sid] - 16'd1;
          end
        end
        default: begin
          r.status      = ST_HDR;
          fr_low[sid]   = b;
          fr_count[sid] = 16'd1;
          fr_left[sid]  = 16'd0;
          fr_phase[sid] = PH_HDR2;
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    beat_result_t want;
    beat_result_t seen;
    if (rst) begin
      for (int unsigned s = 0; s < STREAMS; s++) flush_stream(s);
      act_reg = 5'd16;
      max_reg = 16'd1024;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ACTIVE_STREAMS:   act_reg = cfg_data[4:0];
          REG_MAX_FRAME_LENGTH: max_reg = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        deframe(s_tdata[3:0], s_tdata[11:4], want);
        expected_q.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        seen.sid    = m_tdata[3:0];
        seen.status = status_t'(m_tdata[6:4]);
        seen.data   = m_tdata[14:7];
        seen.offset = m_tdata[30:15];
        seen.last   = m_tlast;
        if (expected_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected output beat: sid=%0d status=%0d byte=%02h off=%0d last=%0b",
                     seen.sid, seen.status, seen.data, seen.offset, seen.last);
        end else begin
          want = expected_q.pop_front();
          checked++;
          if (seen !== want) begin
            fails++;
            if (fails <= 10)
              $display({"beat mismatch: expected sid=%0d status=%0d byte=%02h off=%0d ",
                        "last=%0b, got sid=%0d status=%0d byte=%02h off=%0d last=%0b"},
                       want.sid, want.status, want.data, want.offset, want.last,
                       seen.sid, seen.status, seen.data, seen.offset, seen.last);
          end
        end
      end
    end
    fail_count    <= fails;
    pending_beats <= expected_q.size();
    checked_beats <= checked;
  end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// Top of the deframer testbench: clock, reset, register writes and stream stimulus.
// Depends on mslpd_pkg, the deframer top level and mslpd_checker.
module tb_top;
  import mslpd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_BEATS = 210;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic        m_tlast;
  logic        cfg_we;
  reg_index_t  cfg_index;
  logic [15:0] cfg_data;

  int fail_count;
  int pending_beats;
  int checked_beats;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int cycle_count = 0;
  int beats_sent = 0;
  int reg_writes = 0;
  int cur_act = 16;
  int cur_max = 1024;
  int gen_len [16];
  int gen_pos [16];
  int gen_hdr [16];

  multi_stream_length_prefix_deframer uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  mslpd_checker frame_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_beats(pending_beats),
    .checked_beats(checked_beats)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still awaited",
               cycle_count, pending_beats);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // The output side, including the long hold-off that backs up the pipeline.
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served < hold_requests) begin
        holds_served = holds_served + 1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_beat(input logic [3:0] sid, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'h0, b, sid};
    do @(posedge clk); while (!s_tready);
    beats_sent++;
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [15:0] value);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_beats != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_ACTIVE_STREAMS) cur_act = value[4:0];
    else cur_max = value;
    reg_writes++;
  endtask

  // Mostly well-formed frames, interleaved over the active streams, with short
  // headers, exact fits, overlong frames, stray bytes and inactive streams mixed in.
  task automatic random_beat();
    int act;
    int mx;
    int s;
    int k;
    int r;
    logic [7:0] b;
    act = (cur_act > 16) ? 16 : cur_act;
    mx  = (cur_max < 2) ? 2 : cur_max;
    r   = $urandom_range(99);
    if (act < 16 && (act == 0 || r < 8)) begin
      send_beat(4'($urandom_range(15, act)), 8'($urandom));
    end else if (r >= 97) begin
      send_beat(4'($urandom_range(act - 1, 0)), 8'($urandom));
    end else begin
      s = $urandom_range(act - 1, 0);
      if (gen_pos[s] >= gen_len[s]) begin
        k = $urandom_range(99);
        if (k < 8) begin
          gen_hdr[s] = $urandom_range(1, 0);
          gen_len[s] = 2;
        end else if (k < 16 && mx <= 64) begin
          gen_hdr[s] = mx;
          gen_len[s] = mx;
        end else if (k < 24 && mx <= 64) begin
          gen_hdr[s] = $urandom_range(65535, mx + 1);
          gen_len[s] = mx + 1;
        end else begin
          gen_hdr[s] = $urandom_range((mx < 24) ? mx : 24, 2);
          gen_len[s] = gen_hdr[s];
        end
        gen_pos[s] = 0;
      end
      if (gen_pos[s] == 0) b = gen_hdr[s][7:0];
      else if (gen_pos[s] == 1) b = gen_hdr[s][15:8];
      else b = 8'($urandom);
      gen_pos[s]++;
      send_beat(4'(s), b);
    end
  endtask

  task automatic run_phase(input int act, input int mx, input int idle, input int stall,
                           input bit hold);
    write_reg(REG_ACTIVE_STREAMS, 16'(act));
    write_reg(REG_MAX_FRAME_LENGTH, 16'(mx));
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    if (hold) hold_requests = hold_requests + 1;
    repeat (PHASE_BEATS) random_beat();
  endtask

  initial begin
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= 16'h0000;
    cfg_we    <= 1'b0;
    cfg_index <= REG_ACTIVE_STREAMS;
    cfg_data  <= 16'h0000;
    for (int i = 0; i < 16; i++) begin
      gen_len[i] = 0;
      gen_pos[i] = 0;
      gen_hdr[i] = 0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty body, short lengths, interleaved frames and the largest length.
    send_beat(4'd0, 8'h02);  send_beat(4'd0, 8'h00);
    send_beat(4'd1, 8'h01);  send_beat(4'd1, 8'h00);
    send_beat(4'd2, 8'h00);  send_beat(4'd2, 8'h00);
    send_beat(4'd3, 8'h05);  send_beat(4'd4, 8'h03);
    send_beat(4'd3, 8'h00);  send_beat(4'd4, 8'h00);
    send_beat(4'd3, 8'hFF);  send_beat(4'd4, 8'h7E);
    send_beat(4'd3, 8'hAA);  send_beat(4'd3, 8'h55);
    send_beat(4'd15, 8'hFF); send_beat(4'd15, 8'hFF); send_beat(4'd15, 8'h80);

    // A lowered count rejects stream 15 but keeps its body state.
    write_reg(REG_ACTIVE_STREAMS, 16'd1);
    send_beat(4'd3, 8'h11);  send_beat(4'd15, 8'h22);
    send_beat(4'd0, 8'h03);  send_beat(4'd0, 8'h00);
    write_reg(REG_MAX_FRAME_LENGTH, 16'd0);
    send_beat(4'd0, 8'h44);
    write_reg(REG_ACTIVE_STREAMS, 16'd31);
    send_beat(4'd15, 8'h33);
    write_reg(REG_ACTIVE_STREAMS, 16'd0);
    send_beat(4'd0, 8'h99);  send_beat(4'd15, 8'h0F);

    run_phase(16, 1024, 0, 0, 1'b0);
    run_phase(5, 16, 78, 0, 1'b0);
    run_phase(16, 65535, 0, 78, 1'b0);
    run_phase(1, 1, 18, 18, 1'b0);
    run_phase(31, 40, 0, 0, 1'b1);
    run_phase(12, 300, 18, 18, 1'b0);

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_beats != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Summary: %0d input beats sent, %0d output beats checked, %0d register writes",
             beats_sent, checked_beats, reg_writes);
    $display("Summary: %0d mismatches over idle, stalled and held-off phases", fail_count);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/mslpd_pkg.sv
rtl/core/multi_stream_length_prefix_deframer.sv
bench/mslpd_checker.sv
bench/tb_top.sv
